// ----- rtl/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/dft_pkg.sv -----
package dft_pkg;
    localparam int NumDigits  = 17;
    localparam int MagWidth   = 56;
    localparam int BcdWidth   = 4 * NumDigits;
    localparam int MaxChars   = 47;
    localparam int PlacesCap  = 16;
    localparam int SciLimit   = 20;
    localparam int SpanLimit  = 18;
    localparam int TrBias     = 147;
    localparam int ThirdMul   = 683;
    localparam int TenthMul   = 205;
    localparam int RecipShift = 11;

    localparam logic [1:0] ModeStd = 2'd0;
    localparam logic [1:0] ModeSci = 2'd1;
    localparam logic [1:0] ModeEng = 2'd2;

    localparam logic [2:0] CfgMode      = 3'd0;
    localparam logic [2:0] CfgPoint     = 3'd1;
    localparam logic [2:0] CfgGroup     = 3'd2;
    localparam logic [2:0] CfgGroupSize = 3'd3;
    localparam logic [2:0] CfgMinPlaces = 3'd4;

    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharOne   = 8'h31;
    localparam logic [7:0] CharMinus = 8'h2d;
    localparam logic [7:0] CharE     = 8'h65;
    localparam logic [7:0] CharDot   = 8'h2e;

    typedef struct packed {
        logic              sign;
        logic              lead0;
        logic [4:0]        int_end;
        logic              grp;
        logic              pnt;
        logic signed [8:0] fr_beg;
        logic signed [8:0] fr_end;
        logic signed [8:0] ex_val;
    } t_plan;

    typedef struct packed {
        logic       done;
        logic [4:0] nd;
        logic [4:0] nz;
    } t_bcd_stat;
endpackage

// ----- rtl/dft_bcd.sv -----
module dft_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dft_pkg::MagWidth-1:0]  i_mag,
    output logic [dft_pkg::BcdWidth-1:0]  o_digits,
    output dft_pkg::t_bcd_stat            o_stat
);
    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_SHIFT = 3'b010,
        B_SCAN  = 3'b100
    } t_bstate;

    t_bstate                        r_state;
    logic                           r_done;
    logic [dft_pkg::MagWidth-1:0]   r_bin;
    logic [dft_pkg::BcdWidth-1:0]   r_bcd;
    logic [dft_pkg::BcdWidth-1:0]   n_adj;
    logic [5:0]                     r_step;
    logic [4:0]                     r_pos;
    logic [4:0]                     r_nd;
    logic [4:0]                     r_nz;
    logic [3:0]                     scan_dig;

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int k = 0; k < dft_pkg::NumDigits; k++) begin
            n_adj[k*4 +: 4] = (r_bcd[k*4 +: 4] >= 4'd5) ? r_bcd[k*4 +: 4] + 4'd3
                                                        : r_bcd[k*4 +: 4];
        end
    end

    assign scan_dig = r_bcd[r_pos*4 +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_start) r_state <= B_SHIFT;
                end
                B_SHIFT: begin
                    if (r_step == 6'(dft_pkg::MagWidth - 1)) r_state <= B_SCAN;
                end
                B_SCAN: begin
                    if (r_pos == 5'd0) begin
                        r_state <= B_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_bin  <= i_mag;
                r_step <= 6'd0;
                // digits stay valid for the emitter until the next request
                if (i_start) r_bcd <= '0;
            end
            B_SHIFT: begin
                r_bcd  <= {n_adj[dft_pkg::BcdWidth-2:0], r_bin[dft_pkg::MagWidth-1]};
                r_bin  <= {r_bin[dft_pkg::MagWidth-2:0], 1'b0};
                r_step <= r_step + 6'd1;
                r_pos  <= 5'(dft_pkg::NumDigits - 1);
                r_nd   <= 5'd0;
                r_nz   <= 5'd0;
            end
            B_SCAN: begin
                r_pos <= r_pos - 5'd1;
                if (scan_dig == 4'd0) begin
                    if (r_nd != 5'd0) r_nd <= r_nd + 5'd1;
                    r_nz <= r_nz + 5'd1;
                end else begin
                    r_nd <= r_nd + 5'd1;
                    r_nz <= 5'd0;
                end
            end
            default: ;
        endcase
    end

    assign o_digits    = r_bcd;
    assign o_stat.done = r_done;
    assign o_stat.nd   = r_nd;
    assign o_stat.nz   = r_nz;
endmodule

// ----- rtl/dft_emit.sv -----
`include "assert_macros.svh"
module dft_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  dft_pkg::t_plan                i_plan,
    input  logic [dft_pkg::BcdWidth-1:0]  i_digits,
    input  logic [4:0]                    i_nd,
    input  logic [7:0]                    i_point_char,
    input  logic [7:0]                    i_group_char,
    input  logic [4:0]                    i_group_size,
    output logic [7:0]                    o_text_char,
    output logic                          o_last,
    output logic [5:0]                    o_char_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_done
);
    typedef enum logic [13:0] {
        E_IDLE  = 14'b00000000000001,
        E_SETUP = 14'b00000000000010,
        E_SIGN  = 14'b00000000000100,
        E_LEAD  = 14'b00000000001000,
        E_INT   = 14'b00000000010000,
        E_PNT   = 14'b00000000100000,
        E_FRAC  = 14'b00000001000000,
        E_EXPE  = 14'b00000010000000,
        E_EXPN  = 14'b00000100000000,
        E_EXPH  = 14'b00001000000000,
        E_EXPT  = 14'b00010000000000,
        E_EXPO  = 14'b00100000000000,
        E_TERM  = 14'b01000000000000,
        E_DRAIN = 14'b10000000000000
    } t_estate;

    t_estate           r_state, n_state;
    dft_pkg::t_plan    r_plan;
    logic              r_ovalid;
    logic              r_done;
    logic [7:0]        r_ochar;
    logic              r_olast;
    logic [5:0]        r_ocount;
    logic [5:0]        r_cnt;
    logic signed [8:0] r_idx;
    logic              r_sepd;
    logic [4:0]        r_gmod;
    logic              r_hund;
    logic [6:0]        r_xlow;
    logic [3:0]        r_tens;

    logic              go, emit, put_v;
    logic [7:0]        put_c;
    logic              grp_on, int_done, sep_now, frac_more, idx_ok;
    logic [4:0]        pos;
    logic [7:0]        dig_char;
    logic [8:0]        xabs;
    logic [7:0]        xmag;
    logic [14:0]       tens_prod;
    logic [6:0]        ones;

    function automatic logic [7:0] CharZeroPlus(input logic [3:0] d);
        CharZeroPlus = dft_pkg::CharZero + {4'b0, d};
    endfunction

    assign go        = !r_ovalid || i_out_ready;
    assign grp_on    = r_plan.grp && (i_group_size >= 5'd2);
    assign int_done  = r_idx >= $signed({4'b0, r_plan.int_end});
    assign sep_now   = (r_idx != 9'sd0) && grp_on && (r_gmod == 5'd0) && !r_sepd;
    assign frac_more = r_idx < r_plan.fr_end;
    assign idx_ok    = (r_idx >= 9'sd0) && (r_idx < $signed({4'b0, i_nd}));
    assign pos       = i_nd - 5'd1 - r_idx[4:0];
    assign dig_char  = idx_ok ? CharZeroPlus(i_digits[pos*4 +: 4]) : dft_pkg::CharZero;
    assign xabs      = i_plan.ex_val[8] ? 9'(-i_plan.ex_val) : 9'(i_plan.ex_val);
    assign xmag      = xabs[7:0];
    assign tens_prod = 15'(r_xlow) * 15'(dft_pkg::TenthMul);
    assign ones      = r_xlow - 7'({3'b0, r_tens} * 7'd10);

    always_comb begin
        n_state = r_state;
        put_v   = 1'b0;
        put_c   = dft_pkg::CharZero;
        case (r_state)
            E_IDLE: begin
                if (i_start) n_state = E_SETUP;
            end
            E_SETUP: begin
                if (!(grp_on && r_gmod >= i_group_size)) n_state = E_SIGN;
            end
            E_SIGN: begin
                put_v = r_plan.sign;
                put_c = dft_pkg::CharMinus;
                if (go) n_state = E_LEAD;
            end
            E_LEAD: begin
                put_v = r_plan.lead0;
                if (go) n_state = E_INT;
            end
            E_INT: begin
                if (int_done) begin
                    if (go) n_state = E_PNT;
                end else if (sep_now) begin
                    put_v = 1'b1;
                    put_c = i_group_char;
                end else begin
                    put_v = 1'b1;
                    put_c = dig_char;
                end
            end
            E_PNT: begin
                put_v = r_plan.pnt;
                put_c = i_point_char;
                if (go) n_state = E_FRAC;
            end
            E_FRAC: begin
                if (frac_more) begin
                    put_v = 1'b1;
                    put_c = dig_char;
                end else if (go) begin
                    n_state = E_EXPE;
                end
            end
            E_EXPE: begin
                if (r_plan.ex_val == 9'sd0) begin
                    if (go) n_state = E_TERM;
                end else begin
                    put_v = 1'b1;
                    put_c = dft_pkg::CharE;
                    if (go) n_state = E_EXPN;
                end
            end
            E_EXPN: begin
                put_v = r_plan.ex_val[8];
                put_c = dft_pkg::CharMinus;
                if (go) n_state = E_EXPH;
            end
            E_EXPH: begin
                put_v = r_hund;
                put_c = dft_pkg::CharOne;
                if (go) n_state = E_EXPT;
            end
            E_EXPT: begin
                put_v = (r_tens != 4'd0) || r_hund;
                put_c = CharZeroPlus(r_tens);
                if (go) n_state = E_EXPO;
            end
            E_EXPO: begin
                put_v = 1'b1;
                put_c = CharZeroPlus(ones[3:0]);
                if (go) n_state = E_TERM;
            end
            E_TERM: begin
                if (go) n_state = E_DRAIN;
            end
            E_DRAIN: begin
                if (go) n_state = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase
    end

    assign emit = go && put_v && (put_c != 8'd0) && (r_cnt < 6'(dft_pkg::MaxChars));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_ovalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == E_DRAIN) && go;
            if (go) r_ovalid <= emit || (r_state == E_TERM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            if (r_state == E_TERM) begin
                r_ochar  <= 8'd0;
                r_olast  <= 1'b1;
                r_ocount <= r_cnt;
            end else begin
                r_ochar  <= put_c;
                r_olast  <= 1'b0;
                r_ocount <= 6'd0;
            end
        end
        if (emit) r_cnt <= r_cnt + 6'd1;
        case (r_state)
            E_IDLE: begin
                r_plan <= i_plan;
                r_gmod <= i_plan.int_end;
                r_idx  <= 9'sd0;
                r_sepd <= 1'b0;
                r_cnt  <= 6'd0;
                r_hund <= xmag >= 8'd100;
                r_xlow <= (xmag >= 8'd100) ? 7'(xmag - 8'd100) : xmag[6:0];
            end
            E_SETUP: begin
                if (grp_on && r_gmod >= i_group_size) r_gmod <= r_gmod - i_group_size;
                r_tens <= 4'(tens_prod >> dft_pkg::RecipShift);
            end
            E_INT: begin
                if (go && !int_done) begin
                    if (sep_now) begin
                        r_sepd <= 1'b1;
                    end else begin
                        r_idx  <= r_idx + 9'sd1;
                        r_sepd <= 1'b0;
                        r_gmod <= (r_gmod == 5'd0) ? i_group_size - 5'd1 : r_gmod - 5'd1;
                    end
                end
            end
            E_PNT: begin
                if (go) r_idx <= r_plan.fr_beg;
            end
            E_FRAC: begin
                if (go && frac_more) r_idx <= r_idx + 9'sd1;
            end
            default: ;
        endcase
    end

    assign o_text_char  = r_ochar;
    assign o_last       = r_olast;
    assign o_char_count = r_ocount;
    assign o_out_valid  = r_ovalid;
    assign o_done       = r_done;

    `ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= 6'(dft_pkg::MaxChars))
    `ASSERT_NXT(a_term_after, i_clk, i_rst_n, (r_state == E_TERM) && go, o_out_valid && o_last)
    `ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
endmodule

// ----- rtl/decimal_float_to_text.sv -----
// decimal float to text converter
// input channel: i_number with i_in_valid / o_in_ready; one 64-bit decimal float
// per request, coefficient in bits 63..8 and exponent in bits 7..0
// output channel: o_text_char, o_last, o_char_count with o_out_valid / i_out_ready;
// one character per request, closed by a terminator (char 0, last 1, count)
// config channel: i_cfg_index / i_cfg_data with i_cfg_valid / o_cfg_ready,
// always ready; write only while the block is idle
// o_in_ready is high only in idle; one number at a time
// steps: binary to bcd shifting of the 56-bit magnitude, a scan of the 17
// digits, two plan states (PLAN1, PLAN2), group alignment, then the emitter
// walks through each character or skipped field in order
// the single add-3 shift unit and the emitter, at one character per cycle
// while the receiver is ready, set the rate
// a stalled receiver holds the current request; the emitter waits with it
// reset returns the config registers to their defaults and the block to idle
`include "assert_macros.svh"
module decimal_float_to_text (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_text_char,
    output logic        o_last,
    output logic [5:0]  o_char_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_CONV  = 5'b00010,
        T_PLAN1 = 5'b00100,
        T_PLAN2 = 5'b01000,
        T_EMIT  = 5'b10000
    } t_tstate;

    t_tstate            r_state;
    logic [1:0]         r_mode;
    logic [7:0]         r_point;
    logic [7:0]         r_group;
    logic [4:0]         r_gsize;
    logic [4:0]         r_minpl;
    logic [63:0]        r_num;
    logic signed [9:0]  r_e10;
    logic [6:0]         r_q;

    logic                          in_acc;
    logic [dft_pkg::MagWidth-1:0]  in_mag;
    logic [dft_pkg::BcdWidth-1:0]  digits;
    dft_pkg::t_bcd_stat            bstat;
    dft_pkg::t_plan                plan;
    logic                          emit_done;

    logic signed [9:0] ex, nd_s, sig_s, mp_s, bsum, span, x10;
    logic [17:0]       q_prod;
    logic [9:0]        rem3;
    logic [4:0]        tr;
    logic              use_sci, is_nan, is_zero;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == T_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_mag      = i_number[63] ? dft_pkg::MagWidth'(-i_number[63:8]) : i_number[63:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_mode  <= dft_pkg::ModeStd;
            r_point <= dft_pkg::CharDot;
            r_group <= 8'd0;
            r_gsize <= 5'd3;
            r_minpl <= 5'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dft_pkg::CfgMode:      r_mode  <= i_cfg_data[1:0];
                    dft_pkg::CfgPoint:     r_point <= i_cfg_data;
                    dft_pkg::CfgGroup:     r_group <= i_cfg_data;
                    dft_pkg::CfgGroupSize: r_gsize <= i_cfg_data[4:0];
                    dft_pkg::CfgMinPlaces: r_minpl <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            case (r_state)
                T_IDLE:  if (in_acc) r_state <= T_CONV;
                T_CONV:  if (bstat.done) r_state <= T_PLAN1;
                T_PLAN1: r_state <= T_PLAN2;
                T_PLAN2: r_state <= T_EMIT;
                T_EMIT:  if (emit_done) r_state <= T_IDLE;
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign ex     = 10'(signed'(r_num[7:0]));
    assign nd_s   = $signed({5'b0, bstat.nd});
    assign x10    = ex + nd_s + 10'sd147;
    assign q_prod = 18'(x10[8:0]) * 18'(dft_pkg::ThirdMul);

    // latched input number, exponent plus digit count, and its third for engineering alignment
    always_ff @(posedge i_clk) begin
        if (r_state == T_IDLE && in_acc) r_num <= i_number;
        if (r_state == T_PLAN1) begin
            r_e10 <= ex + nd_s;
            r_q   <= 7'(q_prod >> dft_pkg::RecipShift);
        end
    end

    assign rem3    = 10'(r_e10 + 10'sd147) - 10'({3'b0, r_q} * 10'd3);
    assign tr      = (rem3[1:0] == 2'd0) ? 5'd3 : {3'b0, rem3[1:0]};
    assign is_nan  = (r_num[7:0] == 8'h80);
    assign is_zero = (r_num[63:8] == '0);
    assign sig_s   = $signed({5'b0, 5'(bstat.nd - bstat.nz)});
    assign mp_s    = $signed({5'b0, (r_minpl > 5'(dft_pkg::PlacesCap))
                              ? 5'(dft_pkg::PlacesCap) : r_minpl});
    assign bsum    = ex + nd_s;
    assign span    = sig_s - r_e10;

    always_comb begin
        plan    = '0;
        use_sci = 1'b0;
        if (!is_nan) begin
            if (is_zero) begin
                plan.lead0 = 1'b1;
            end else begin
                plan.sign = r_num[63];
                case (r_mode)
                    dft_pkg::ModeSci: use_sci = 1'b1;
                    dft_pkg::ModeEng: begin
                        plan.int_end = tr;
                        plan.pnt     = $signed({5'b0, tr}) < sig_s;
                        plan.fr_beg  = 9'($signed({5'b0, tr}));
                        plan.fr_end  = 9'(sig_s);
                        plan.ex_val  = 9'(r_e10 - $signed({5'b0, tr}));
                    end
                    default: begin
                        if (!ex[9]) begin
                            if (bsum + mp_s > 10'(dft_pkg::SciLimit)) begin
                                use_sci = 1'b1;
                            end else begin
                                plan.int_end = bsum[4:0];
                                plan.grp     = 1'b1;
                                plan.pnt     = mp_s != 10'sd0;
                                plan.fr_beg  = 9'(bsum);
                                plan.fr_end  = 9'(bsum + mp_s);
                            end
                        end else if (r_e10 <= 10'sd0) begin
                            if (span > 10'(dft_pkg::SpanLimit)) begin
                                use_sci = 1'b1;
                            end else begin
                                plan.lead0  = 1'b1;
                                plan.pnt    = 1'b1;
                                plan.fr_beg = 9'(r_e10);
                                plan.fr_end = (span < mp_s) ? 9'(mp_s + r_e10) : 9'(sig_s);
                            end
                        end else begin
                            plan.int_end = r_e10[4:0];
                            plan.grp     = 1'b1;
                            plan.pnt     = 1'b1;
                            plan.fr_beg  = 9'(r_e10);
                            plan.fr_end  = (sig_s - r_e10 < mp_s) ? 9'(mp_s + r_e10)
                                                                  : 9'(sig_s);
                        end
                    end
                endcase
                if (use_sci) begin
                    plan.int_end = 5'd1;
                    plan.grp     = 1'b0;
                    plan.lead0   = 1'b0;
                    plan.pnt     = sig_s > 10'sd1;
                    plan.fr_beg  = 9'sd1;
                    plan.fr_end  = 9'(sig_s);
                    plan.ex_val  = 9'(r_e10 - 10'sd1);
                end
            end
        end
    end

    dft_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc),
        .i_mag    (in_mag),
        .o_digits (digits),
        .o_stat   (bstat)
    );

    dft_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_state == T_PLAN2),
        .i_plan       (plan),
        .i_digits     (digits),
        .i_nd         (bstat.nd),
        .i_point_char (r_point),
        .i_group_char (r_group),
        .i_group_size (r_gsize),
        .o_text_char  (o_text_char),
        .o_last       (o_last),
        .o_char_count (o_char_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_done       (emit_done)
    );

    `ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, in_acc, !o_in_ready)
    `ASSERT_IMP(a_out_in_emit, i_clk, i_rst_n, o_out_valid, r_state == T_EMIT)
    `ASSERT_IMP(a_conv_done, i_clk, i_rst_n, bstat.done, r_state == T_CONV)
endmodule

// ----- sim/decimal_float_to_text_tb.sv -----
`timescale 1ns / 1ps
module decimal_float_to_text_tb;
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [5:0] count;
    } t_text_item;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [7:0]  data;
        logic [63:0] number;
        bit          typed;
        string       text;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_number = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_text_char;
    logic        o_last;
    logic [5:0]  o_char_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    decimal_float_to_text i_dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow registers
    logic [1:0] fmt_mode;
    logic [7:0] point_ch;
    logic [7:0] group_ch;
    logic [4:0] group_len;
    logic [4:0] min_frac;

    int          dg_buf [17];
    int          dg_n;
    int          dg_tz;
    logic [7:0]  line_q [$];
    t_text_item  pending_text [$];
    int          errors = 0;
    bit          no_stall = 1'b0;
    int          stall_left = 0;

    function automatic longint unsigned pow10(int n);
        longint unsigned p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    function automatic void put_ch(logic [7:0] c);
        if (c != 8'd0 && line_q.size() < dft_pkg::MaxChars) line_q.push_back(c);
    endfunction

    function automatic void put_at(int i);
        if (i < 0 || i >= dg_n) put_ch(dft_pkg::CharZero);
        else put_ch(dft_pkg::CharZero + 8'(dg_buf[i]));
    endfunction

    function automatic void put_range(int a, int b);
        for (int i = a; i < b; i++) put_at(i);
    endfunction

    function automatic void put_grouped(int b);
        int g = int'(group_len);
        if (g < 2) begin
            put_range(0, b);
            return;
        end
        for (int i = 0; i < b; i++) begin
            if (i > 0 && (b - i) % g == 0) put_ch(group_ch);
            put_at(i);
        end
    endfunction

    function automatic void put_exp(int x);
        bit hundred = 1'b0;
        if (x == 0) return;
        put_ch(dft_pkg::CharE);
        if (x < 0) begin
            x = -x;
            put_ch(dft_pkg::CharMinus);
        end
        if (x >= 100) begin
            put_ch(dft_pkg::CharOne);
            x -= 100;
            hundred = 1'b1;
        end
        if (x >= 10 || hundred) put_ch(dft_pkg::CharZero + 8'(x / 10));
        put_ch(dft_pkg::CharZero + 8'(x % 10));
    endfunction

    function automatic void put_sci(int ex);
        int sig = dg_n - dg_tz;
        put_at(0);
        if (sig > 1) begin
            put_ch(point_ch);
            put_range(1, sig);
        end
        put_exp(ex + dg_n - 1);
    endfunction

    function automatic void put_eng(int ex);
        int e10 = ex + dg_n;
        int sig = dg_n - dg_tz;
        int tr = e10 % 3;
        if (tr <= 0) tr += 3;
        put_range(0, tr);
        if (tr < sig) begin
            put_ch(point_ch);
            put_range(tr, sig);
        end
        put_exp(e10 - tr);
    endfunction

    function automatic void put_std(int ex);
        int mp = (min_frac > dft_pkg::PlacesCap) ? dft_pkg::PlacesCap : int'(min_frac);
        int a;
        int b;
        if (ex >= 0) begin
            b = dg_n + ex;
            if (b + mp > dft_pkg::SciLimit) put_sci(ex);
            else begin
                put_grouped(b);
                if (mp > 0) begin
                    put_ch(point_ch);
                    put_range(b, b + mp);
                end
            end
            return;
        end
        a = ex + dg_n;
        b = dg_n - dg_tz;
        if (a <= 0) begin
            if (b - a > dft_pkg::SpanLimit) put_sci(ex);
            else begin
                put_ch(dft_pkg::CharZero);
                put_ch(point_ch);
                if (b - a < mp) b = mp + a;
                put_range(a, b);
            end
        end else begin
            put_grouped(a);
            put_ch(point_ch);
            if (b - a < mp) b = mp + a;
            put_range(a, b);
        end
    endfunction

    function automatic void push_line();
        foreach (line_q[k]) pending_text.push_back('{line_q[k], 1'b0, 6'd0});
        pending_text.push_back('{8'd0, 1'b1, 6'(line_q.size())});
    endfunction

    function automatic void predict_text(logic [63:0] w);
        int ex = int'($signed(w[7:0]));
        logic [55:0] m = w[63] ? -w[63:8] : w[63:8];
        longint unsigned mag = 64'(m);
        longint unsigned d;
        line_q.delete();
        if (ex != -128) begin
            if (mag == 0) put_ch(dft_pkg::CharZero);
            else begin
                dg_n = 0;
                dg_tz = 0;
                for (int i = dft_pkg::NumDigits - 1; i >= 0; i--) begin
                    d = mag / pow10(i);
                    mag -= d * pow10(i);
                    dg_buf[dg_n] = int'(d);
                    if (d == 0) begin
                        if (dg_n != 0) dg_n++;
                        dg_tz++;
                    end else begin
                        dg_n++;
                        dg_tz = 0;
                    end
                end
                if (w[63]) put_ch(dft_pkg::CharMinus);
                if (fmt_mode == dft_pkg::ModeSci) put_sci(ex);
                else if (fmt_mode == dft_pkg::ModeEng) put_eng(ex);
                else put_std(ex);
            end
        end
        push_line();
    endfunction

    function automatic void push_typed(string s);
        line_q.delete();
        for (int k = 0; k < s.len(); k++) line_q.push_back(s[k]);
        push_line();
    endfunction

    function automatic logic [63:0] make_number(longint c, int e);
        return {c[55:0], e[7:0]};
    endfunction

    function automatic logic [63:0] rand_number();
        int sel = $urandom_range(0, 19);
        int nd = $urandom_range(1, 17);
        longint unsigned c = {$urandom, $urandom} % pow10(nd);
        int e = $urandom_range(0, 50) - 25;
        if (sel == 0) return {$urandom, $urandom};
        if (sel == 1) return {32'($urandom), 24'($urandom), 8'h80};
        if (sel == 2) return {56'd0, 8'($urandom)};
        if (sel == 3) e = $urandom_range(0, 255);
        if (c > 64'h007f_ffff_ffff_ffff) c = {$urandom, $urandom} >> 9;
        if ($urandom_range(0, 1)) c = -c;
        return make_number(longint'(c), e);
    endfunction

    always @(posedge i_clk) begin
        if (no_stall) i_out_ready <= 1'b1;
        else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                            : $urandom_range(1, 3);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_text.size() == 0) begin
                $error("unexpected result char=%0h last=%0b", o_text_char, o_last);
                errors++;
            end else begin
                t_text_item e;
                e = pending_text.pop_front();
                if (o_text_char !== e.ch) begin
                    $error("text_char expected %0h actual %0h", e.ch, o_text_char);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0b actual %0b", e.last, o_last);
                    errors++;
                end
                if (o_char_count !== e.count) begin
                    $error("char_count expected %0d actual %0d", e.count, o_char_count);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        wait (pending_text.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] data);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dft_pkg::CfgMode:      fmt_mode = data[1:0];
            dft_pkg::CfgPoint:     point_ch = data;
            dft_pkg::CfgGroup:     group_ch = data;
            dft_pkg::CfgGroupSize: group_len = data[4:0];
            dft_pkg::CfgMinPlaces: min_frac = data[4:0];
            default: ;
        endcase
    endtask

    task automatic send_number(logic [63:0] w, bit typed, string s);
        int gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        repeat (gap) @(posedge i_clk);
        @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_number <= w;
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
        if (typed) push_typed(s);
        else predict_text(w);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd255;
            2: return dft_pkg::CharDot;
            default: return 8'($urandom);
        endcase
    endfunction

    t_stim_row rows [$];

    function automatic void add_num(logic [63:0] w, bit typed = 0, string s = "");
        rows.push_back('{1'b0, 3'd0, 8'd0, w, typed, s});
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [7:0] data);
        rows.push_back('{1'b1, idx, data, 64'd0, 1'b0, ""});
    endfunction

    initial begin
        fmt_mode = dft_pkg::ModeStd;
        point_ch = dft_pkg::CharDot;
        group_ch = 8'd0;
        group_len = 5'd3;
        min_frac = 5'd0;

        add_num({56'd5, 8'h80}, 1, "");
        add_num(make_number(0, 7), 1, "0");
        add_num(make_number(0, -100), 1, "0");
        add_num(make_number(1, 0), 1, "1");
        add_num(make_number(-1, 0), 1, "-1");
        add_num(make_number(12345, -2), 1, "123.45");
        add_num(make_number(5, -3), 1, "0.005");
        add_num(make_number(100, -1), 1, "10.");
        add_num(make_number(64'h007f_ffff_ffff_ffff, 0));
        add_num(make_number(-64'sh0080_0000_0000_0000, 127));
        add_num(make_number(7, -127));
        add_cfg(dft_pkg::CfgMode, 8'(dft_pkg::ModeSci));
        add_num(make_number(12345, 0), 1, "1.2345e4");
        add_num(make_number(-3, -128 + 1));
        add_cfg(dft_pkg::CfgMode, 8'(dft_pkg::ModeEng));
        add_num(make_number(12345, 0), 1, "12.345e3");
        add_num(make_number(5, -7));
        add_cfg(dft_pkg::CfgMode, 8'd3);
        add_cfg(dft_pkg::CfgPoint, 8'd0);
        add_cfg(dft_pkg::CfgGroup, 8'h2c);
        add_num(make_number(1234567, -1));
        add_cfg(dft_pkg::CfgGroupSize, 8'd0);
        add_num(make_number(1234567, 0));
        add_cfg(dft_pkg::CfgGroupSize, 8'd31);
        add_num(make_number(-1234567, 3));
        add_cfg(dft_pkg::CfgGroupSize, 8'd17);
        add_cfg(dft_pkg::CfgMinPlaces, 8'd31);
        add_num(make_number(42, 0));
        add_num(make_number(42, -5));
        add_cfg(dft_pkg::CfgMinPlaces, 8'd16);
        add_num(make_number(9, -20));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].is_cfg) write_reg(rows[r].idx, rows[r].data);
            else send_number(rows[r].number, rows[r].typed, rows[r].text);
        end

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(dft_pkg::CfgMode, (ph < 4) ? 8'(ph) : 8'($urandom_range(0, 3)));
            write_reg(dft_pkg::CfgPoint, pick_char());
            write_reg(dft_pkg::CfgGroup, pick_char());
            write_reg(dft_pkg::CfgGroupSize,
                      (ph == 1) ? 8'd31 : 8'($urandom_range(0, 17)));
            write_reg(dft_pkg::CfgMinPlaces,
                      (ph == 0) ? 8'd16 : 8'($urandom_range(0, 31)));
            no_stall = (ph == 2);
            for (int n = 0; n < 24; n++) begin
                if (ph == 4 && n == 12) wait (pending_text.size() == 0);
                send_number(rand_number(), 0, "");
            end
        end

        drain();
        if (errors == 0 && pending_text.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
